/* rtl/pnm_pkg.sv */
`default_nettype none
package pnm_pkg;

	// Register map (index = paddr[3:2])
	localparam logic [1:0] REG_ASCII_MODE = 2'd0;
	localparam logic [1:0] REG_PIXEL_KIND = 2'd1;
	localparam logic [1:0] REG_ROW_WIDTH  = 2'd2;

	// Pixel kind codes
	localparam logic [1:0] KIND_BITMAP = 2'd0;
	localparam logic [1:0] KIND_GREY   = 2'd1;
	localparam logic [1:0] KIND_COLOUR = 2'd2;

	localparam int ROW_W = 13;
	localparam int DEFAULT_MAX_WIDTH = 4096;
	localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 13'd570;
	localparam logic [1:0] PIXEL_KIND_RESET = KIND_COLOUR;

	// Pixels per text line
	localparam logic [6:0] LINE_BITMAP = 7'd70;
	localparam logic [6:0] LINE_GREY   = 7'd16;
	localparam logic [6:0] LINE_COLOUR = 7'd5;

	// Characters
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_ONE     = 8'h31;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;

	// Byte slots of one pixel's job, sent lowest first
	localparam int SLOTS    = 12;
	localparam int SLOT_R_H = 0;
	localparam int SLOT_R_T = 1;
	localparam int SLOT_R_O = 2;
	localparam int SLOT_SP1 = 3;
	localparam int SLOT_G_H = 4;
	localparam int SLOT_G_T = 5;
	localparam int SLOT_G_O = 6;
	localparam int SLOT_SP2 = 7;
	localparam int SLOT_B_H = 8;
	localparam int SLOT_B_T = 9;
	localparam int SLOT_B_O = 10;
	localparam int SLOT_TERM = 11;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [SLOTS-1:0][7:0] data;
		logic [SLOTS-1:0]      mask;
	} pnm_job_t;

	// Split a byte into hundreds, tens and ones: {h, t, o}
	function automatic logic [11:0] to_digits(input logic [7:0] v);
		logic [3:0] h;
		logic [3:0] t;
		logic [7:0] rem;
		logic [7:0] ones;
		h = 4'd0;
		t = 4'd0;
		if (v >= 8'd200) begin
			h = 4'd2;
		end else if (v >= 8'd100) begin
			h = 4'd1;
		end
		rem = v - ({4'd0, h} * 8'd100);
		for (int k = 1; k < 10; k++) begin
			if (rem >= 8'(k * 10)) begin
				t = 4'(k);
			end
		end
		ones = rem - ({4'd0, t} * 8'd10);
		return {h, t, ones[3:0]};
	endfunction

endpackage
`default_nettype wire

/* rtl/pnm_raster_body_encoder.sv */
// Path: an accepted pixel's job is written into the job queue, and its first byte then goes through
// the back end's output register to m_tdata.
// Throughput: one output byte per cycle while m_tready is high; a pixel gives 0 to 12 bytes
// (twelve for ASCII colour), sent through the single-byte output register of the back end.
// Input takes one pixel per cycle while the two-entry job queue has room.
// Reset: asynchronous, clears row/line/bit state and the queue, registers to their defaults.
`default_nettype none
module pnm_raster_body_encoder
	import pnm_pkg::*;
#(
	parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // out_byte[7:0]
	output logic             m_tlast,   // run_end
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic             ascii_mode_q;
	logic [1:0]       pixel_kind_q;
	logic [ROW_W-1:0] row_width_q;

	logic             wr_en;
	logic             accept;
	logic             push;
	pnm_job_t         push_job;
	pnm_job_t         head;
	logic             full;
	logic             empty;
	logic             pop;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ascii_mode_q <= 1'b0;
			pixel_kind_q <= PIXEL_KIND_RESET;
			row_width_q  <= ROW_WIDTH_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_ASCII_MODE: ascii_mode_q <= pwdata[0];
				REG_PIXEL_KIND: pixel_kind_q <= pwdata[1:0];
				REG_ROW_WIDTH:  row_width_q  <= pwdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (paddr[3:2])
			REG_ASCII_MODE: prdata = {31'd0, ascii_mode_q};
			REG_PIXEL_KIND: prdata = {30'd0, pixel_kind_q};
			REG_ROW_WIDTH:  prdata = {{(32-ROW_W){1'b0}}, row_width_q};
			default:        prdata = 32'd0;
		endcase
	end

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	pnm_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.red       (s_tdata[7:0]),
		.green     (s_tdata[15:8]),
		.blue      (s_tdata[23:16]),
		.ascii_mode(ascii_mode_q),
		.pixel_kind(pixel_kind_q),
		.row_width (row_width_q),
		.push      (push),
		.job       (push_job)
	);

	pnm_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (full),
		.pop     (pop),
		.head    (head),
		.empty   (empty)
	);

	pnm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule
`default_nettype wire

/* rtl/pnm_front.sv */
`default_nettype none
module pnm_front
	import pnm_pkg::*;
#(
	parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       red,
	input  wire logic [7:0]       green,
	input  wire logic [7:0]       blue,
	input  wire logic             ascii_mode,
	input  wire logic [1:0]       pixel_kind,
	input  wire logic [ROW_W-1:0] row_width,
	output logic                  push,
	output pnm_job_t              job
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int XW = ((CW > ROW_W) ? CW : ROW_W) + 1;

	logic [CW-1:0] column_q;
	logic [6:0]    line_pixels_q;
	logic [7:0]    bit_acc_q;
	logic [2:0]    bit_count_q;

	logic [1:0]    kind;
	logic [XW-1:0] width_raw;
	logic [XW-1:0] width_eff;
	logic          row_end;
	logic          black;
	logic [6:0]    lp_next;
	logic [6:0]    limit;
	logic          brk;
	logic [7:0]    acc_next;
	logic [3:0]    cnt_next;
	logic [11:0]   dig_r;
	logic [11:0]   dig_g;
	logic [11:0]   dig_b;
	logic          acc_flush;

	// Clamp row width and detect the row end
	always_comb begin
		kind = (pixel_kind == KIND_BITMAP || pixel_kind == KIND_GREY) ? pixel_kind : KIND_COLOUR;
		width_raw = XW'(row_width);
		if (width_raw == '0) begin
			width_eff = XW'(1);
		end else if (width_raw > XW'(MAX_WIDTH)) begin
			width_eff = XW'(MAX_WIDTH);
		end else begin
			width_eff = width_raw;
		end
		row_end = (XW'(column_q) + XW'(1)) >= width_eff;
	end

	assign black    = (red == 8'd0);
	assign lp_next  = line_pixels_q + 7'd1;
	assign acc_next = {bit_acc_q[6:0], black};
	assign cnt_next = {1'b0, bit_count_q} + 4'd1;
	assign dig_r    = to_digits(red);
	assign dig_g    = to_digits(green);
	assign dig_b    = to_digits(blue);

	always_comb begin
		case (kind)
			KIND_BITMAP: limit = LINE_BITMAP;
			KIND_GREY:   limit = LINE_GREY;
			default:     limit = LINE_COLOUR;
		endcase
		brk = (lp_next >= limit) || row_end;
	end

	// Build the byte slots for this pixel
	always_comb begin
		job = '0;
		acc_flush = 1'b0;
		if (ascii_mode) begin
			case (kind)
				KIND_BITMAP: begin
					job.data[SLOT_R_O] = black ? CH_ONE : CH_ZERO;
					job.mask[SLOT_R_O] = 1'b1;
				end
				default: begin
					job.data[SLOT_R_H] = {4'h3, dig_r[11:8]};
					job.data[SLOT_R_T] = {4'h3, dig_r[7:4]};
					job.data[SLOT_R_O] = {4'h3, dig_r[3:0]};
					job.mask[SLOT_R_H] = (dig_r[11:8] != 4'd0);
					job.mask[SLOT_R_T] = (dig_r[11:4] != 8'd0);
					job.mask[SLOT_R_O] = 1'b1;
					if (kind == KIND_COLOUR) begin
						job.data[SLOT_SP1] = CH_SPACE;
						job.data[SLOT_SP2] = CH_SPACE;
						job.mask[SLOT_SP1] = 1'b1;
						job.mask[SLOT_SP2] = 1'b1;
						job.data[SLOT_G_H] = {4'h3, dig_g[11:8]};
						job.data[SLOT_G_T] = {4'h3, dig_g[7:4]};
						job.data[SLOT_G_O] = {4'h3, dig_g[3:0]};
						job.mask[SLOT_G_H] = (dig_g[11:8] != 4'd0);
						job.mask[SLOT_G_T] = (dig_g[11:4] != 8'd0);
						job.mask[SLOT_G_O] = 1'b1;
						job.data[SLOT_B_H] = {4'h3, dig_b[11:8]};
						job.data[SLOT_B_T] = {4'h3, dig_b[7:4]};
						job.data[SLOT_B_O] = {4'h3, dig_b[3:0]};
						job.mask[SLOT_B_H] = (dig_b[11:8] != 4'd0);
						job.mask[SLOT_B_T] = (dig_b[11:4] != 8'd0);
						job.mask[SLOT_B_O] = 1'b1;
					end
				end
			endcase
			// Line break, or a separator for decimal kinds
			if (brk) begin
				job.data[SLOT_TERM] = CH_NEWLINE;
				job.mask[SLOT_TERM] = 1'b1;
			end else if (kind != KIND_BITMAP) begin
				job.data[SLOT_TERM] = CH_SPACE;
				job.mask[SLOT_TERM] = 1'b1;
			end
		end else begin
			case (kind)
				KIND_BITMAP: begin
					if (cnt_next[3]) begin
						job.data[0] = acc_next;
						job.mask[0] = 1'b1;
						acc_flush = 1'b1;
					end else if (row_end) begin
						job.data[0] = acc_next << (4'd8 - cnt_next);
						job.mask[0] = 1'b1;
						acc_flush = 1'b1;
					end
				end
				KIND_GREY: begin
					job.data[0] = red;
					job.mask[0] = 1'b1;
				end
				default: begin
					job.data[0] = red;
					job.data[1] = green;
					job.data[2] = blue;
					job.mask[2:0] = 3'b111;
				end
			endcase
		end
	end

	assign push = accept && (job.mask != '0);

	// Advance row, line and bit state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q      <= '0;
			line_pixels_q <= '0;
			bit_acc_q     <= '0;
			bit_count_q   <= '0;
		end else if (accept) begin
			if (row_end) begin
				column_q      <= '0;
				line_pixels_q <= '0;
				bit_acc_q     <= '0;
				bit_count_q   <= '0;
			end else begin
				column_q <= column_q + CW'(1);
				if (ascii_mode) begin
					line_pixels_q <= brk ? 7'd0 : lp_next;
				end else if (kind == KIND_BITMAP) begin
					bit_acc_q   <= acc_flush ? 8'd0 : acc_next;
					bit_count_q <= acc_flush ? 3'd0 : cnt_next[2:0];
				end
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/pnm_queue.sv */
`default_nettype none
module pnm_queue
	import pnm_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire pnm_job_t push_job,
	output logic          full,
	input  wire logic     pop,
	output pnm_job_t      head,
	output logic          empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	pnm_job_t      mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full  = (count_q == NW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Store jobs
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Move pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(DEPTH))
		else $error("queue count above depth");
`endif

endmodule
`default_nettype wire

/* rtl/pnm_back.sv */
`default_nettype none
module pnm_back
	import pnm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire pnm_job_t head,
	input  wire logic     empty,
	output logic          pop,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	output logic [7:0]    m_tdata,   // out_byte[7:0]
	output logic          m_tlast    // run_end
);

	logic [SLOTS-1:0]      cur_mask_q;
	logic [SLOTS-1:0][7:0] cur_data_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_last_q;

	logic                  adv;
	logic                  use_cur;
	logic [SLOTS-1:0]      src_mask;
	logic [SLOTS-1:0][7:0] src_data;
	logic [SLOTS-1:0]      lowest;
	logic [SLOTS-1:0]      rem;
	logic [7:0]            sel_byte;
	logic                  emit;

	// Pick the source job and its lowest pending slot
	always_comb begin
		adv      = !out_valid_q || m_tready;
		use_cur  = (cur_mask_q != '0);
		src_mask = use_cur ? cur_mask_q : (empty ? '0 : head.mask);
		src_data = use_cur ? cur_data_q : head.data;
		lowest   = src_mask & (~src_mask + SLOTS'(1));
		rem      = src_mask & ~lowest;
		sel_byte = '0;
		for (int i = 0; i < SLOTS; i++) begin
			sel_byte = sel_byte | (src_data[i] & {8{lowest[i]}});
		end
		emit = adv && (src_mask != '0);
		pop  = adv && !use_cur && !empty;
	end

	// Output register and remaining slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cur_mask_q  <= '0;
		end else if (adv) begin
			out_valid_q <= emit;
			if (emit) begin
				cur_mask_q <= rem;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= sel_byte;
			out_last_q <= (rem == '0);
		end
		if (pop) begin
			cur_data_q <= head.data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	a_cur_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_mask_q != '0) |-> out_valid_q)
		else $error("pending slots without a byte on the output");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (rem == '0)) |=> (cur_mask_q == '0))
		else $error("slots left after the last byte of a run");
`endif

endmodule
`default_nettype wire
